>>> hdl/assert_macros.svh
// Assertion macros used by the checker file art_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with asynchronous reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/art_pkg.sv
// Package for the AES round transform: types, request codes, S-box tables,
// and GF(2^8) helpers. No dependencies.
package art_pkg;

    typedef enum logic [1:0] {
        REQ_KEY_ADD = 2'd0,
        REQ_FULL    = 2'd1,
        REQ_FINAL   = 2'd2,
        REQ_SPARE   = 2'd3
    } req_t;

    typedef logic [7:0] byte_t;
    typedef byte_t state_t [16];

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        inverse_dir;
        logic [1:0]  req_type;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } out_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8) modulo x^8+x^4+x^3+x+1.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

>>> hdl/art_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Depends on art_pkg for nothing; payload width comes from the instance type.
interface art_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/art_mix.sv
// Forward and inverse MixColumns on one four-byte column.
// Depends on art_pkg (xtime).
module art_mix (
    input  logic [31:0] col,
    input  logic        inverse_dir,
    output logic [31:0] mixed
);
    logic [7:0] b [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            b[k]  = col[31 - 8 * k -: 8];
            x2[k] = art_pkg::xtime(b[k]);
            x4[k] = art_pkg::xtime(x2[k]);
            x8[k] = art_pkg::xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ b[k];
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int r = 0; r < 4; r++)
        begin
            if (inverse_dir)
                mixed[31 - 8 * r -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4]
                                       ^ m9[(r + 3) % 4];
            else
                mixed[31 - 8 * r -: 8] = m2[r] ^ m3[(r + 1) % 4] ^ b[(r + 2) % 4]
                                       ^ b[(r + 3) % 4];
        end
    end
endmodule

>>> hdl/art_round.sv
// Combinational AES round: byte substitution, row shift, column mix, key add.
// Depends on art_pkg and art_mix.
module art_round (
    input  art_pkg::in_item_t  item,
    output art_pkg::out_item_t result
);
    logic [127:0] blk;
    logic [127:0] key;
    logic [127:0] enc_sub;
    logic [127:0] dec_sub;
    logic [127:0] pre_mix;
    logic [127:0] mix_out;
    logic [127:0] res;
    logic [1:0]   req;
    logic         full;
    logic         active;

    assign blk    = {item.block_high, item.block_low};
    assign key    = {item.key_high, item.key_low};
    assign req    = item.req_type;
    assign full   = (req == art_pkg::REQ_FULL);
    assign active = (req == art_pkg::REQ_FULL) || (req == art_pkg::REQ_FINAL);

    // Byte i lives at bits 127-8i. Encrypt: S-box then shift; decrypt: shift then inv S-box.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                enc_sub[127 - 8 * (c * 4 + r) -: 8] =
                    art_pkg::SBOX[blk[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
                dec_sub[127 - 8 * (c * 4 + r) -: 8] =
                    art_pkg::INV_SBOX[blk[127 - 8 * (((c + 4 - r) % 4) * 4 + r) -: 8]];
            end
        end
    end

    // Encrypt adds the key after the mix, decrypt before it.
    assign pre_mix = item.inverse_dir ? (dec_sub ^ key) : enc_sub;

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        art_mix u_mix (
            .col         (pre_mix[127 - 32 * c -: 32]),
            .inverse_dir (item.inverse_dir),
            .mixed       (mix_out[127 - 32 * c -: 32])
        );
    end

    always_comb
    begin
        if (!active)
            res = blk ^ key;
        else if (item.inverse_dir)
            res = full ? mix_out : pre_mix;
        else
            res = (full ? mix_out : pre_mix) ^ key;
    end

    assign result.out_high = res[127:64];
    assign result.out_low  = res[63:0];
endmodule

>>> hdl/aes_round_transform_core.sv
// Top level of the AES round transform: input register, round logic,
// output register. Depends on art_pkg, art_stream_if and art_round.
//
// One AES-128 round per transaction: encrypt or decrypt, full round, final
// round without column mix, or key add only (request code 3 also adds the
// key only). The block takes a transaction every cycle unless a stalled
// output holds a full input stage. Each transaction goes from the input
// register through the round logic into the output register. Both stages
// advance together whenever the output stage is empty or being drained,
// so throughput is one transaction per cycle with no bubbles; a stalled
// output holds the output stage, and the input stage once it is full. State
// byte 0 sits in bits 63:56 of the high half, matching the key layout.
module aes_round_transform_core (
    input  logic     clk,
    input  logic     rst_n,
    art_stream_if.sink   in_if,
    art_stream_if.source out_if
);
    logic                valid_in_reg;
    logic                valid_out_reg;
    logic                adv_out;
    logic                adv_in;
    art_pkg::in_item_t   item_reg;
    art_pkg::out_item_t  result_reg;
    art_pkg::out_item_t  result_next;

    // Advance the output stage when it is empty or being taken.
    assign adv_out = !valid_out_reg || out_if.ready;
    // Advance the input stage when its content can move on.
    assign adv_in  = !valid_in_reg || adv_out;

    assign in_if.ready = adv_in;

    art_round u_round (
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in_reg  <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                valid_in_reg <= in_if.valid;
            if (adv_out)
                valid_out_reg <= valid_in_reg;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (adv_in && in_if.valid)
            item_reg <= in_if.data;
        if (adv_out && valid_in_reg)
            result_reg <= result_next;
    end

    assign out_if.valid = valid_out_reg;
    assign out_if.data  = result_reg;
endmodule

>>> hdl/art_checker.sv
// Port-level checker for aes_round_transform_core, with its bind.
// Depends on assert_macros.svh and art_pkg.
`include "assert_macros.svh"

module art_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input art_pkg::out_item_t out_data
);
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
    `ASSERT_CLK(a_ready_free, clk, rst_n, out_ready |-> in_ready, "input blocked while output drains")
    `ASSERT_CLK(a_latency, clk, rst_n, in_valid && in_ready ##1 out_ready |=> out_valid, "result did not appear after two cycles")
    `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid, "result valid in reset")
endmodule

bind aes_round_transform_core art_checker u_art_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
);
